[src/assert_macros.svh]
// assertion macros used by the rtl queue (lgc_queue)
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define LGC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen outside reset
`define LGC_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[src/lgc_pkg.sv]
// shared types and constants of the line gradient color block
`default_nettype none

package lgc_pkg;

	localparam int FRACTION_BITS_DEF = 16;
	localparam int COLOR_W = 24;
	localparam int CH_W = 8;
	localparam int COORD_W = 16;
	localparam int DIFF_W = 17;
	localparam int MAG_W = 16;
	localparam int MIDQ_DEPTH = 4;
	localparam int OUTQ_DEPTH = 2;

	localparam logic [COLOR_W-1:0] WHITE_COLOR = 24'hFFFFFF;
	localparam logic [COLOR_W-1:0] BLACK_COLOR = 24'h000000;
	localparam logic [CH_W-1:0] CH_MAX = 8'hFF;

	typedef enum logic [1:0] {
		T_DIV   = 2'd0,
		T_ZERO  = 2'd1,
		T_ONE   = 2'd2,
		T_WHITE = 2'd3
	} tcode_t;

	typedef enum logic [1:0] {
		BOOST_NONE  = 2'd0,
		BOOST_RED   = 2'd1,
		BOOST_GREEN = 2'd2,
		BOOST_BLUE  = 2'd3
	} boost_t;

	typedef struct packed {
		logic [COLOR_W-1:0] color_a;
		logic [COLOR_W-1:0] color_b;
		logic signed [COORD_W-1:0] start_x;
		logic signed [COORD_W-1:0] start_y;
		logic signed [COORD_W-1:0] end_x;
		logic signed [COORD_W-1:0] end_y;
		logic signed [COORD_W-1:0] pixel_x;
		logic signed [COORD_W-1:0] pixel_y;
	} in_item_t;

	// classified request handed from front to back
	typedef struct packed {
		logic [COLOR_W-1:0] color_a;
		logic [COLOR_W-1:0] color_b;
		tcode_t code;
		logic [MAG_W-1:0] num;
		logic [MAG_W-1:0] den;
	} fq_item_t;

	// channel times 1.5, truncated, saturated at 255
	function automatic logic [CH_W-1:0] boost_ch(input logic [CH_W-1:0] c);
		logic [CH_W:0] v;
		v = {1'b0, c} + {2'b00, c[CH_W-1:1]};
		return v[CH_W] ? CH_MAX : v[CH_W-1:0];
	endfunction

endpackage

`default_nettype wire

[src/lgc_queue.sv]
// small register queue used between the block's parts and at its output
`default_nettype none
`include "assert_macros.svh"

module lgc_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      rdata,
	output logic                  empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0] wptr_q;
	logic [AW-1:0] rptr_q;
	logic [CW-1:0] count_q;

	function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= ptr_next(wptr_q);
			end
			if (pop) begin
				rptr_q <= ptr_next(rptr_q);
			end
			count_q <= count_q + CW'(push) - CW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	assign rdata = mem_q[rptr_q];
	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);

	`LGC_ASSERT_NEVER(a_push_full, clk, arst_n, push && full, "queue written while full")
	`LGC_ASSERT_NEVER(a_pop_empty, clk, arst_n, pop && empty, "queue read while empty")
	`LGC_ASSERT(a_count, clk, arst_n, count_q <= CW'(DEPTH), "queue fill count past depth")

endmodule

`default_nettype wire

[src/lgc_front.sv]
// front end: takes requests, picks the major axis and classifies the fraction
`default_nettype none

module lgc_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	output logic                  full,
	input  wire lgc_pkg::in_item_t in_item,
	output logic                  q_push,
	output lgc_pkg::fq_item_t     q_item,
	input  wire logic             q_full
);

	localparam int DW = lgc_pkg::DIFF_W;
	localparam int MW = lgc_pkg::MAG_W;

	logic adv;

	logic valid_s1;
	logic valid_s2;
	logic [lgc_pkg::COLOR_W-1:0] ca_s1;
	logic [lgc_pkg::COLOR_W-1:0] cb_s1;
	logic black_s1;
	logic signed [DW-1:0] dx_s1;
	logic signed [DW-1:0] dy_s1;
	logic signed [DW-1:0] nx_s1;
	logic signed [DW-1:0] ny_s1;
	lgc_pkg::fq_item_t item_s2;

	logic [MW-1:0] ax;
	logic [MW-1:0] ay;
	logic [MW-1:0] anx;
	logic [MW-1:0] any_y;
	logic use_x;
	logic signed [DW-1:0] num_sel;
	logic signed [DW-1:0] den_sel;
	logic ge_x;
	logic ge_y;
	lgc_pkg::fq_item_t item_nxt;

	function automatic logic [MW-1:0] mag(input logic signed [DW-1:0] v);
		logic signed [DW-1:0] n;
		n = v[DW-1] ? -v : v;
		return n[MW-1:0];
	endfunction

	assign adv  = !(valid_s2 && q_full);
	assign full = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= push;
			valid_s2 <= valid_s1;
		end
	end

	// stage 1: coordinate differences and the both-black check
	always_ff @(posedge clk) begin
		if (adv) begin
			ca_s1    <= in_item.color_a;
			cb_s1    <= in_item.color_b;
			black_s1 <= (in_item.color_a == lgc_pkg::BLACK_COLOR) &&
				(in_item.color_b == lgc_pkg::BLACK_COLOR);
			dx_s1 <= DW'(in_item.end_x) - DW'(in_item.start_x);
			dy_s1 <= DW'(in_item.end_y) - DW'(in_item.start_y);
			nx_s1 <= DW'(in_item.pixel_x) - DW'(in_item.start_x);
			ny_s1 <= DW'(in_item.pixel_y) - DW'(in_item.start_y);
		end
	end

	// stage 2: magnitudes, axis pick, saturation cases
	always_comb begin
		ax    = mag(dx_s1);
		ay    = mag(dy_s1);
		anx   = mag(nx_s1);
		any_y = mag(ny_s1);
		use_x = ax > ay;
		ge_x  = anx >= ax;
		ge_y  = any_y >= ay;
		num_sel = use_x ? nx_s1 : ny_s1;
		den_sel = use_x ? dx_s1 : dy_s1;

		item_nxt.color_a = ca_s1;
		item_nxt.color_b = cb_s1;
		item_nxt.num     = use_x ? anx : any_y;
		item_nxt.den     = use_x ? ax : ay;
		if (black_s1) begin
			item_nxt.code = lgc_pkg::T_WHITE;
		end else if (den_sel == '0) begin
			item_nxt.code = lgc_pkg::T_ONE;
		end else if ((num_sel != '0) && (num_sel[DW-1] != den_sel[DW-1])) begin
			item_nxt.code = lgc_pkg::T_ZERO;
		end else if (use_x ? ge_x : ge_y) begin
			item_nxt.code = lgc_pkg::T_ONE;
		end else begin
			item_nxt.code = lgc_pkg::T_DIV;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s2 <= item_nxt;
		end
	end

	assign q_push = valid_s2 && adv;
	assign q_item = item_s2;

endmodule

`default_nettype wire

[src/lgc_back.sv]
// back end: pipelined fraction divider, channel blend and boost
`default_nettype none

module lgc_back #(
	parameter int FRACTION_BITS = lgc_pkg::FRACTION_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         q_empty,
	output logic                              q_pop,
	input  wire lgc_pkg::fq_item_t            q_item,
	input  wire lgc_pkg::boost_t              boost_mode,
	input  wire logic                         o_full,
	output logic                              o_push,
	output logic [lgc_pkg::COLOR_W-1:0]       o_color
);

	localparam int FB = FRACTION_BITS;
	localparam int MW = lgc_pkg::MAG_W;
	localparam int CW = lgc_pkg::CH_W;
	localparam int PW = FB + 11;

	typedef struct packed {
		logic [lgc_pkg::COLOR_W-1:0] color_a;
		logic [lgc_pkg::COLOR_W-1:0] color_b;
		lgc_pkg::tcode_t code;
		logic [MW-1:0] den;
		logic [MW-1:0] rem;
		logic [FB-1:0] quot;
	} div_item_t;

	logic adv;

	logic [FB:0] div_vld_s;
	div_item_t div_s [FB+1];

	logic mul_vld_s;
	lgc_pkg::tcode_t mul_code_s;
	logic [CW-1:0] mul_base_s [3];
	logic signed [PW-1:0] mul_prod_s [3];

	logic [FB:0] t_val;
	logic [CW-1:0] blend_ch [3];
	logic [CW-1:0] out_ch [3];

	assign adv   = !(mul_vld_s && o_full);
	assign q_pop = adv && !q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_vld_s <= '0;
			mul_vld_s <= 1'b0;
		end else if (adv) begin
			div_vld_s <= {div_vld_s[FB-1:0], q_pop};
			mul_vld_s <= div_vld_s[FB];
		end
	end

	// load: remainder starts at the numerator, which is below the denominator for T_DIV requests
	always_ff @(posedge clk) begin
		if (adv) begin
			div_s[0].color_a <= q_item.color_a;
			div_s[0].color_b <= q_item.color_b;
			div_s[0].code    <= q_item.code;
			div_s[0].den     <= q_item.den;
			div_s[0].rem     <= q_item.num;
			div_s[0].quot    <= '0;
		end
	end

	// one quotient bit per stage, restoring division
	for (genvar k = 1; k <= FB; k++) begin : g_div
		logic [MW:0] r2;
		logic ge;
		div_item_t nxt;

		always_comb begin
			r2  = {div_s[k-1].rem, 1'b0};
			ge  = r2 >= {1'b0, div_s[k-1].den};
			nxt = div_s[k-1];
			nxt.rem  = ge ? MW'(r2 - {1'b0, div_s[k-1].den}) : r2[MW-1:0];
			nxt.quot = {div_s[k-1].quot[FB-2:0], ge};
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				div_s[k] <= nxt;
			end
		end
	end

	always_comb begin
		case (div_s[FB].code)
			lgc_pkg::T_ONE:  t_val = {1'b1, {FB{1'b0}}};
			lgc_pkg::T_ZERO: t_val = '0;
			default:         t_val = {1'b0, div_s[FB].quot};
		endcase
	end

	// multiply stage: (end - start) * t per channel
	for (genvar c = 0; c < 3; c++) begin : g_mul
		logic [CW-1:0] s_ch;
		logic [CW-1:0] e_ch;
		logic signed [CW:0] diff;
		logic signed [PW-1:0] sum;

		assign s_ch = div_s[FB].color_a[c*CW +: CW];
		assign e_ch = div_s[FB].color_b[c*CW +: CW];
		assign diff = $signed({1'b0, e_ch}) - $signed({1'b0, s_ch});

		always_ff @(posedge clk) begin
			if (adv) begin
				mul_base_s[c] <= s_ch;
				mul_prod_s[c] <= PW'(diff) * PW'($signed({1'b0, t_val}));
			end
		end

		// sum is never negative, so the top bits are the truncated channel
		assign sum = mul_prod_s[c] + $signed({3'b000, mul_base_s[c], {FB{1'b0}}});
		assign blend_ch[c] = sum[FB+CW-1:FB];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mul_code_s <= div_s[FB].code;
		end
	end

	always_comb begin
		out_ch[2] = (boost_mode == lgc_pkg::BOOST_RED) ?
			lgc_pkg::boost_ch(blend_ch[2]) : blend_ch[2];
		out_ch[1] = (boost_mode == lgc_pkg::BOOST_GREEN) ?
			lgc_pkg::boost_ch(blend_ch[1]) : blend_ch[1];
		out_ch[0] = (boost_mode == lgc_pkg::BOOST_BLUE) ?
			lgc_pkg::boost_ch(blend_ch[0]) : blend_ch[0];
		if (mul_code_s == lgc_pkg::T_WHITE) begin
			o_color = lgc_pkg::WHITE_COLOR;
		end else begin
			o_color = {out_ch[2], out_ch[1], out_ch[0]};
		end
	end

	assign o_push = mul_vld_s && !o_full;

endmodule

`default_nettype wire

[src/line_gradient_color.sv]
// top level of the line gradient color block
`default_nettype none

// Line gradient color: gives the 24-bit RGB color (red in the top byte) of one
// pixel on a line between two endpoints. Both endpoint colors black gives white.
// Otherwise the position fraction t is taken along the major axis (x when
// |end_x - start_x| > |end_y - start_y|, else y) as unsigned Q1.FRACTION_BITS,
// clamped to 0 before the start and to 1.0 at or past the end or when the
// endpoints coincide on that axis; each channel is start + (end - start) * t,
// truncated, and the channel that boost_mode picks is scaled by 1.5 and
// saturated at 255. Rate: one request per cycle while neither side stalls; both
// sides may stall freely. A result passes through the front stages, the middle
// queue, the divider load stage, the FRACTION_BITS divider stages, the multiply
// stage and the result queue before it shows on the result ports; the divider
// resolves one quotient bit per pipeline stage. boost_mode is written through
// boost_mode_we/boost_mode_wdata and must only change while the block is empty.
module line_gradient_color #(
	parameter int FRACTION_BITS = lgc_pkg::FRACTION_BITS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// request side
	input  wire logic                                push,
	output logic                                     full,
	input  wire logic [lgc_pkg::COLOR_W-1:0]         color_a,
	input  wire logic [lgc_pkg::COLOR_W-1:0]         color_b,
	input  wire logic signed [lgc_pkg::COORD_W-1:0]  start_x,
	input  wire logic signed [lgc_pkg::COORD_W-1:0]  start_y,
	input  wire logic signed [lgc_pkg::COORD_W-1:0]  end_x,
	input  wire logic signed [lgc_pkg::COORD_W-1:0]  end_y,
	input  wire logic signed [lgc_pkg::COORD_W-1:0]  pixel_x,
	input  wire logic signed [lgc_pkg::COORD_W-1:0]  pixel_y,
	// result side
	output logic                                     empty,
	input  wire logic                                pop,
	output logic [lgc_pkg::COLOR_W-1:0]              pixel_color,
	// configuration
	input  wire logic                                boost_mode_we,
	input  wire logic [1:0]                          boost_mode_wdata
);

	lgc_pkg::boost_t boost_mode_q;
	lgc_pkg::in_item_t in_item;

	// front to middle queue
	logic mq_push;
	logic mq_full;
	logic mq_pop;
	logic mq_empty;
	lgc_pkg::fq_item_t mq_wdata;
	lgc_pkg::fq_item_t mq_rdata;

	// back to result queue
	logic oq_push;
	logic oq_full;
	logic [lgc_pkg::COLOR_W-1:0] oq_wdata;

	// boost select register; the user must write it only while idle, the block does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			boost_mode_q <= lgc_pkg::BOOST_NONE;
		end else if (boost_mode_we) begin
			boost_mode_q <= lgc_pkg::boost_t'(boost_mode_wdata);
		end
	end

	always_comb begin
		in_item.color_a = color_a;
		in_item.color_b = color_b;
		in_item.start_x = start_x;
		in_item.start_y = start_y;
		in_item.end_x   = end_x;
		in_item.end_y   = end_y;
		in_item.pixel_x = pixel_x;
		in_item.pixel_y = pixel_y;
	end

	// front: axis choice and classification of the fraction
	lgc_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.in_item (in_item),
		.q_push  (mq_push),
		.q_item  (mq_wdata),
		.q_full  (mq_full)
	);

	// decoupling queue, lets front and back stall independently
	lgc_queue #(
		.WIDTH ($bits(lgc_pkg::fq_item_t)),
		.DEPTH (lgc_pkg::MIDQ_DEPTH)
	) u_midq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mq_push),
		.wdata  (mq_wdata),
		.full   (mq_full),
		.pop    (mq_pop),
		.rdata  (mq_rdata),
		.empty  (mq_empty)
	);

	// back: divider pipeline, blend, boost
	lgc_back #(
		.FRACTION_BITS (FRACTION_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (mq_empty),
		.q_pop      (mq_pop),
		.q_item     (mq_rdata),
		.boost_mode (boost_mode_q),
		.o_full     (oq_full),
		.o_push     (oq_push),
		.o_color    (oq_wdata)
	);

	// result queue, holds finished colors while the consumer stalls
	lgc_queue #(
		.WIDTH (lgc_pkg::COLOR_W),
		.DEPTH (lgc_pkg::OUTQ_DEPTH)
	) u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (oq_push),
		.wdata  (oq_wdata),
		.full   (oq_full),
		.pop    (pop && !empty),
		.rdata  (pixel_color),
		.empty  (empty)
	);

endmodule

`default_nettype wire
